// ===== hw/rtl/dnw_pkg.sv =====
package dnw_pkg;

  localparam int OFF_W  = 9;
  localparam int DATA_W = 8;
  localparam int LEN_W  = 10;
  localparam int TGT_W  = 14;
  localparam int NEXT_W = 10;
  localparam int POS_W  = 14;
  // Wide enough for a pointer target plus a full label and two more bytes.
  localparam int CUR_W  = 15;
  localparam int PTR_LOW_W = 6;

  localparam logic [DATA_W-1:0] PTR_MASK = 8'hC0;
  localparam logic [DATA_W-1:0] LEN_MASK = 8'h3F;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  typedef enum logic [1:0] {
    EV_LABEL   = 2'd0,
    EV_POINTER = 2'd1,
    EV_DONE    = 2'd2,
    EV_ERROR   = 2'd3
  } ev_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE = 3'd0,
    ERR_ROOM = 3'd1,
    ERR_ZERO = 3'd2,
    ERR_PAST = 3'd3,
    ERR_CAP  = 3'd4
  } err_code_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_RDB,
    S_RDN,
    S_RDL,
    S_EMIT,
    S_DONE
  } state_t;

  typedef struct packed {
    ev_kind_t          kind;
    logic [OFF_W-1:0]  label_offset;
    logic [DATA_W-1:0] label_length;
    logic              dot_follows;
    logic [TGT_W-1:0]  pointer_target;
    logic [NEXT_W-1:0] next_offset;
    err_code_t         error_code;
    logic              last;
  } evt_t;

  typedef struct packed {
    logic [CUR_W-1:0] sum;
    logic             gt;
    logic             ge;
  } alu_res_t;

  function automatic evt_t mk_error(err_code_t code);
    evt_t e;
    e            = '0;
    e.kind       = EV_ERROR;
    e.error_code = code;
    e.last       = 1'b1;
    return e;
  endfunction

endpackage

// ===== hw/rtl/dnw_in_if.sv =====
interface dnw_in_if;
  import dnw_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [OFF_W-1:0]  offset;
  logic [DATA_W-1:0] data_byte;
  logic [LEN_W-1:0]  message_length;

  modport source (output valid, command, offset, data_byte, message_length, input ready);
  modport sink   (input valid, command, offset, data_byte, message_length, output ready);
endinterface

// ===== hw/rtl/dnw_out_if.sv =====
interface dnw_out_if;
  import dnw_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        event_kind;
  logic [OFF_W-1:0]  label_offset;
  logic [DATA_W-1:0] label_length;
  logic              dot_follows;
  logic [TGT_W-1:0]  pointer_target;
  logic [NEXT_W-1:0] next_offset;
  logic [2:0]        error_code;
  logic              last;

  modport source (output valid, event_kind, label_offset, label_length, dot_follows,
                  pointer_target, next_offset, error_code, last, input ready);
  modport sink   (input valid, event_kind, label_offset, label_length, dot_follows,
                  pointer_target, next_offset, error_code, last, output ready);
endinterface

// ===== hw/rtl/dns_name_label_walker_core.sv =====
// Load: one byte a cycle when idle, ready again in the next cycle; it gives no result.
// Decode: each label passes a bounds check, length read, next-byte read and tail read,
// each followed pointer the first three; every event then waits in S_EMIT for a free
// output register. Steps are serialised by the single read port of the message store
// and the one shared adder with its limit comparisons.
// Reset is synchronous, active low; the message store is not cleared.
module dns_name_label_walker_core #(
  parameter int MSG_BYTES  = 512,
  parameter int MAX_HOPS   = 16,
  parameter int MAX_EVENTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  dnw_in_if.sink      in_ch,
  dnw_out_if.source   out_ch
);
  import dnw_pkg::*;

  localparam int AW    = $clog2(MSG_BYTES);
  localparam int HOP_W = $clog2(MAX_HOPS + 1);
  localparam int EV_W  = $clog2(MAX_EVENTS + 1);
  localparam logic [CUR_W-1:0] MSG_LIM = CUR_W'(MSG_BYTES);
  localparam logic [HOP_W-1:0] HOP_LIM = HOP_W'(MAX_HOPS);
  localparam logic [EV_W-1:0]  EV_LIM  = EV_W'(MAX_EVENTS - 2);

  state_t            state_r, state_nxt, ret_r, ret_nxt;
  logic [POS_W-1:0]  cursor_r, cursor_nxt;
  logic [NEXT_W-1:0] resume_r, resume_nxt;
  logic              pseen_r, pseen_nxt;
  logic [HOP_W-1:0]  hop_r, hop_nxt;
  logic [EV_W-1:0]   evcnt_r, evcnt_nxt;
  logic [CUR_W-1:0]  end_r, end_nxt;
  logic [CUR_W-1:0]  c1_r, c1_nxt;
  logic [CUR_W-1:0]  plen_r, plen_nxt;
  logic [DATA_W-1:0] b_r, b_nxt;
  logic [NEXT_W-1:0] done_off_r, done_off_nxt;
  evt_t              pend_r, pend_nxt;
  evt_t              out_evt_r, out_evt_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [CUR_W-1:0]  alu_a, alu_b;
  alu_res_t          alu;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic              st_we;

  logic in_acc, acc_decode, out_free, b_is_ptr, ev_cap, hop_cap, zero_bad, dot;
  logic [CUR_W-1:0] len_ext;

  assign in_acc     = in_ch.valid && in_ch.ready;
  assign acc_decode = in_acc && (in_ch.command == CMD_DECODE);
  assign st_we      = in_acc && (in_ch.command == CMD_LOAD) && (CUR_W'(in_ch.offset) < MSG_LIM);
  assign out_free   = !out_valid_r || out_ch.ready;
  assign b_is_ptr   = ((b_r & PTR_MASK) == PTR_MASK);
  assign ev_cap     = (evcnt_r > EV_LIM);
  assign hop_cap    = (hop_r >= HOP_LIM);
  assign zero_bad   = (b_r == '0) && (rd_data != '0);
  assign dot        = (rd_data != '0);
  assign len_ext    = CUR_W'(in_ch.message_length);

  dnw_alu u_alu (
    .opa (alu_a),
    .opb (alu_b),
    .lim (end_r),
    .res (alu)
  );

  dnw_store #(
    .DEPTH (MSG_BYTES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .we      (st_we),
    .waddr   (AW'(in_ch.offset)),
    .wdata   (in_ch.data_byte),
    .raddr   (rd_addr),
    .rdata_r (rd_data)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc_decode) state_nxt = S_CHK;
      end
      S_CHK:  state_nxt = alu.gt ? S_EMIT : S_RDB;
      S_RDB:  state_nxt = S_RDN;
      S_RDN: begin
        if (b_is_ptr || zero_bad || alu.ge || ev_cap) state_nxt = S_EMIT;
        else state_nxt = S_RDL;
      end
      S_RDL:  state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) state_nxt = ret_r;
      end
      S_DONE: state_nxt = S_EMIT;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath control and register updates.
  always_comb begin
    ret_nxt       = ret_r;
    cursor_nxt    = cursor_r;
    resume_nxt    = resume_r;
    pseen_nxt     = pseen_r;
    hop_nxt       = hop_r;
    evcnt_nxt     = evcnt_r;
    end_nxt       = end_r;
    c1_nxt        = c1_r;
    plen_nxt      = plen_r;
    b_nxt         = b_r;
    done_off_nxt  = done_off_r;
    pend_nxt      = pend_r;
    out_evt_nxt   = out_evt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    alu_a         = CUR_W'(cursor_r);
    alu_b         = '0;
    rd_addr       = cursor_r[AW-1:0];
    in_ch.ready   = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (acc_decode) begin
          cursor_nxt = POS_W'(in_ch.offset);
          resume_nxt = '0;
          pseen_nxt  = 1'b0;
          hop_nxt    = '0;
          evcnt_nxt  = '0;
          end_nxt    = (len_ext > MSG_LIM) ? MSG_LIM : len_ext;
        end
      end
      S_CHK: begin
        alu_b = CUR_W'(2);
        if (alu.gt) begin
          pend_nxt = mk_error(ERR_ROOM);
          ret_nxt  = S_IDLE;
        end
      end
      S_RDB: begin
        alu_b   = CUR_W'(1);
        rd_addr = alu.sum[AW-1:0];
        c1_nxt  = alu.sum;
        b_nxt   = rd_data;
      end
      S_RDN: begin
        alu_a   = c1_r;
        alu_b   = b_is_ptr ? CUR_W'(1) : CUR_W'(b_r);
        rd_addr = alu.sum[AW-1:0];
        if (b_is_ptr) begin
          ret_nxt = S_IDLE;
          if (hop_cap || ev_cap) begin
            pend_nxt = mk_error(ERR_CAP);
          end else begin
            pend_nxt                = '0;
            pend_nxt.kind           = EV_POINTER;
            pend_nxt.pointer_target = {b_r[PTR_LOW_W-1:0], rd_data};
            cursor_nxt              = {b_r[PTR_LOW_W-1:0], rd_data};
            hop_nxt                 = hop_r + HOP_W'(1);
            ret_nxt                 = S_CHK;
            if (!pseen_r) begin
              pseen_nxt  = 1'b1;
              resume_nxt = alu.sum[NEXT_W-1:0];
            end
          end
        end else if (zero_bad) begin
          pend_nxt = mk_error(ERR_ZERO);
          ret_nxt  = S_IDLE;
        end else if (alu.ge) begin
          // The label and the byte after it must both lie inside the message.
          pend_nxt = mk_error(ERR_PAST);
          ret_nxt  = S_IDLE;
        end else if (ev_cap) begin
          pend_nxt = mk_error(ERR_CAP);
          ret_nxt  = S_IDLE;
        end else begin
          plen_nxt = alu.sum;
        end
      end
      S_RDL: begin
        alu_a                 = plen_r;
        alu_b                 = CUR_W'(1);
        pend_nxt              = '0;
        pend_nxt.kind         = EV_LABEL;
        pend_nxt.label_offset = c1_r[OFF_W-1:0];
        pend_nxt.label_length = b_r;
        pend_nxt.dot_follows  = dot;
        if (dot) begin
          cursor_nxt = plen_r[POS_W-1:0];
          ret_nxt    = S_CHK;
        end else begin
          done_off_nxt = pseen_r ? resume_r : alu.sum[NEXT_W-1:0];
          ret_nxt      = S_DONE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_evt_nxt   = pend_r;
          out_valid_nxt = 1'b1;
          evcnt_nxt     = evcnt_r + EV_W'(1);
        end
      end
      S_DONE: begin
        pend_nxt             = '0;
        pend_nxt.kind        = EV_DONE;
        pend_nxt.next_offset = done_off_r;
        pend_nxt.last        = 1'b1;
        ret_nxt              = S_IDLE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      cursor_r    <= '0;
      resume_r    <= '0;
      pseen_r     <= 1'b0;
      hop_r       <= '0;
      evcnt_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      cursor_r    <= cursor_nxt;
      resume_r    <= resume_nxt;
      pseen_r     <= pseen_nxt;
      hop_r       <= hop_nxt;
      evcnt_r     <= evcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    end_r      <= end_nxt;
    c1_r       <= c1_nxt;
    plen_r     <= plen_nxt;
    b_r        <= b_nxt;
    done_off_r <= done_off_nxt;
    pend_r     <= pend_nxt;
    out_evt_r  <= out_evt_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.event_kind     = out_evt_r.kind;
  assign out_ch.label_offset   = out_evt_r.label_offset;
  assign out_ch.label_length   = out_evt_r.label_length;
  assign out_ch.dot_follows    = out_evt_r.dot_follows;
  assign out_ch.pointer_target = out_evt_r.pointer_target;
  assign out_ch.next_offset    = out_evt_r.next_offset;
  assign out_ch.error_code     = out_evt_r.error_code;
  assign out_ch.last           = out_evt_r.last;

  a_last_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_evt_r.last |->
      (out_evt_r.kind == EV_DONE) || (out_evt_r.kind == EV_ERROR))
    else $error("final event is neither done nor error");

  a_event_bound: assert property (@(posedge clk) disable iff (!rst_n)
    evcnt_r <= EV_W'(MAX_EVENTS))
    else $error("event count beyond its cap");

  a_hop_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hop_r <= HOP_LIM)
    else $error("hop count beyond its cap");

  a_decode_starts: assert property (@(posedge clk) disable iff (!rst_n)
    acc_decode |=> (state_r == S_CHK) && (evcnt_r == '0))
    else $error("decode transfer did not start a walk");
endmodule

// ===== hw/rtl/dnw_alu.sv =====
module dnw_alu (
  input  logic [dnw_pkg::CUR_W-1:0] opa,
  input  logic [dnw_pkg::CUR_W-1:0] opb,
  input  logic [dnw_pkg::CUR_W-1:0] lim,
  output dnw_pkg::alu_res_t         res
);
  import dnw_pkg::*;

  logic [CUR_W-1:0] sum;

  assign sum     = opa + opb;
  assign res.sum = sum;
  assign res.gt  = (sum > lim);
  assign res.ge  = (sum >= lim);
endmodule

// ===== hw/rtl/dnw_store.sv =====
module dnw_store #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [dnw_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [dnw_pkg::DATA_W-1:0] rdata_r
);
  import dnw_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end
endmodule

// ===== tb/dnw_event_checker.sv =====
`timescale 1ns / 1ps

module dnw_event_checker #(
  parameter int MSG_BYTES  = 512,
  parameter int MAX_HOPS   = 16,
  parameter int MAX_EVENTS = 64
) (
  input  logic clk,
  input  logic rst_n,
  dnw_in_if    in_ch,
  dnw_out_if   out_ch,
  output int   fail_count,
  output int   pending,
  output int   decode_count,
  output int   label_count,
  output int   pointer_count,
  output int   done_count,
  output int   error_count
);
  import dnw_pkg::*;

  logic [DATA_W-1:0] shadow_store [MSG_BYTES];
  evt_t              expected_events [$];
  int                failures;
  int                decodes;
  int                labels;
  int                pointers;
  int                dones;
  int                errors;

  assign fail_count    = failures;
  assign decode_count  = decodes;
  assign label_count   = labels;
  assign pointer_count = pointers;
  assign done_count    = dones;
  assign error_count   = errors;

  function automatic void push_event(ev_kind_t kind, int loff, int llen, bit dot, int tgt,
                                     int nxt, err_code_t code, bit last);
    evt_t e;
    e                = '0;
    e.kind           = kind;
    e.label_offset   = OFF_W'(loff);
    e.label_length   = DATA_W'(llen);
    e.dot_follows    = dot;
    e.pointer_target = TGT_W'(tgt);
    e.next_offset    = NEXT_W'(nxt);
    e.error_code     = code;
    e.last           = last;
    expected_events.push_back(e);
  endfunction

  // Walks the name from start over the shadow store and queues every event it yields.
  function automatic void predict_walk(int start, int msg_len);
    int lim, pos, len, p, hops, emitted, resume, tgt;
    bit jumped, walking;
    lim     = (msg_len > MSG_BYTES) ? MSG_BYTES : msg_len;
    pos     = start;
    hops    = 0;
    emitted = 0;
    resume  = 0;
    jumped  = 1'b0;
    walking = 1'b1;
    while (walking) begin
      if (pos + 2 > lim) begin
        push_event(EV_ERROR, 0, 0, 0, 0, 0, ERR_ROOM, 1'b1);
        walking = 1'b0;
      end else if ((shadow_store[pos] & PTR_MASK) == PTR_MASK) begin
        tgt = ((shadow_store[pos] & LEN_MASK) << 8) | shadow_store[pos + 1];
        if (hops >= MAX_HOPS || emitted + 2 > MAX_EVENTS) begin
          push_event(EV_ERROR, 0, 0, 0, 0, 0, ERR_CAP, 1'b1);
          walking = 1'b0;
        end else begin
          // Only the first pointer fixes where the name ends in the message.
          if (!jumped) begin
            jumped = 1'b1;
            resume = pos + 2;
          end
          hops++;
          push_event(EV_POINTER, 0, 0, 0, tgt, 0, ERR_NONE, 1'b0);
          emitted++;
          pos = tgt;
        end
      end else begin
        len = shadow_store[pos];
        p   = pos + 1;
        if (len == 0 && shadow_store[p] != 0) begin
          push_event(EV_ERROR, 0, 0, 0, 0, 0, ERR_ZERO, 1'b1);
          walking = 1'b0;
        end else if (p + len + 1 > lim) begin
          push_event(EV_ERROR, 0, 0, 0, 0, 0, ERR_PAST, 1'b1);
          walking = 1'b0;
        end else if (emitted + 2 > MAX_EVENTS) begin
          push_event(EV_ERROR, 0, 0, 0, 0, 0, ERR_CAP, 1'b1);
          walking = 1'b0;
        end else if (shadow_store[p + len] != 0) begin
          push_event(EV_LABEL, p, len, 1'b1, 0, 0, ERR_NONE, 1'b0);
          emitted++;
          pos = p + len;
        end else begin
          push_event(EV_LABEL, p, len, 1'b0, 0, 0, ERR_NONE, 1'b0);
          pos = p + len + 1;
          push_event(EV_DONE, 0, 0, 0, 0, jumped ? resume : pos, ERR_NONE, 1'b1);
          walking = 1'b0;
        end
      end
    end
  endfunction

  task automatic note_failure(string what, evt_t exp);
    failures++;
    if (failures <= 10) begin
      $display("%s at %0t ns: expected kind %0d lofs %0d llen %0d dot %0d ptr %0d",
               what, $time, exp.kind, exp.label_offset, exp.label_length, exp.dot_follows,
               exp.pointer_target);
      $display("    expected next %0d err %0d last %0d",
               exp.next_offset, exp.error_code, exp.last);
      $display("    actual kind %0d lofs %0d llen %0d dot %0d ptr %0d",
               out_ch.event_kind, out_ch.label_offset, out_ch.label_length, out_ch.dot_follows,
               out_ch.pointer_target);
      $display("    actual next %0d err %0d last %0d",
               out_ch.next_offset, out_ch.error_code, out_ch.last);
    end
  endtask

  always @(posedge clk) begin
    evt_t exp;
    if (rst_n) begin
      // Results are checked before the input transfer, which cannot yield one in this cycle.
      if (out_ch.valid && out_ch.ready) begin
        case (out_ch.event_kind)
          EV_LABEL:   labels++;
          EV_POINTER: pointers++;
          EV_DONE:    dones++;
          default:    errors++;
        endcase
        if (expected_events.size() == 0) begin
          note_failure("Unexpected result", '0);
        end else begin
          exp = expected_events.pop_front();
          if (out_ch.event_kind !== exp.kind || out_ch.label_offset !== exp.label_offset ||
              out_ch.label_length !== exp.label_length ||
              out_ch.dot_follows !== exp.dot_follows ||
              out_ch.pointer_target !== exp.pointer_target ||
              out_ch.next_offset !== exp.next_offset ||
              out_ch.error_code !== exp.error_code || out_ch.last !== exp.last) begin
            note_failure("Wrong result", exp);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.command == CMD_LOAD) begin
          if (in_ch.offset < MSG_BYTES) begin
            shadow_store[in_ch.offset] = in_ch.data_byte;
          end
        end else begin
          decodes++;
          predict_walk(in_ch.offset, in_ch.message_length);
        end
      end
      pending <= expected_events.size();
    end
  end

endmodule

// ===== tb/tb_dns_name_label_walker_core.sv =====
`timescale 1ns / 1ps

module tb_dns_name_label_walker_core;
  import dnw_pkg::*;

  localparam int MSG_BYTES  = 512;
  localparam int MAX_HOPS   = 16;
  localparam int MAX_EVENTS = 64;
  localparam int RANDOM_ITEMS = 100;
  // Random walks are kept inside this low window of the store, which is written in full.
  localparam int WIN = 128;

  logic clk = 1'b0;
  logic rst_n;
  bit   sink_ready;
  bit   calm;
  int   items_sent;
  int   load_total;
  int   name_starts [$];
  logic [7:0] image [MSG_BYTES];

  int fail_count, pending, decode_count;
  int label_count, pointer_count, done_count, error_count;

  dnw_in_if  in_ch ();
  dnw_out_if out_ch ();

  always #5 clk = ~clk;

  dns_name_label_walker_core #(
    .MSG_BYTES  (MSG_BYTES),
    .MAX_HOPS   (MAX_HOPS),
    .MAX_EVENTS (MAX_EVENTS)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  dnw_event_checker #(
    .MSG_BYTES  (MSG_BYTES),
    .MAX_HOPS   (MAX_HOPS),
    .MAX_EVENTS (MAX_EVENTS)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .decode_count  (decode_count),
    .label_count   (label_count),
    .pointer_count (pointer_count),
    .done_count    (done_count),
    .error_count   (error_count)
  );

  assign out_ch.ready = sink_ready;

  always @(posedge clk) begin
    sink_ready <= calm || ($urandom_range(99) >= 22);
  end

  task automatic send_item(input logic cmd, input int off, input int data, input int mlen);
    if (!calm && $urandom_range(99) < 22) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.command        <= cmd;
    in_ch.offset         <= OFF_W'(off);
    in_ch.data_byte      <= DATA_W'(data);
    in_ch.message_length <= LEN_W'(mlen);
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic load_byte(input int addr, input int value);
    send_item(CMD_LOAD, addr, value, $urandom_range(1023));
    load_total++;
  endtask

  task automatic decode_name(input int start, input int mlen);
    send_item(CMD_DECODE, start, $urandom_range(255), mlen);
  endtask

  // The last item has just been taken, so the sender drops valid before it waits.
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic int pick_length(int base);
    int r;
    r = $urandom_range(9);
    if (r < 7) return WIN;
    if (r < 9) return $urandom_range(WIN);
    return base + $urandom_range(16);
  endfunction

  // Only length bytes, pointer bytes and end markers are written; label characters never matter.
  task automatic write_name(input int base);
    int pos, len, nlab, lab, tgt;
    pos = base;
    if ($urandom_range(7) == 0) begin
      load_byte(pos, 0);
      load_byte(pos + 1, 0);
    end else begin
      nlab = $urandom_range(5, 1);
      for (lab = 0; lab < nlab; lab++) begin
        len = ($urandom_range(14) == 0) ? $urandom_range(191, 13) : $urandom_range(12, 1);
        if (pos + len + 3 > WIN) break;
        load_byte(pos, len);
        pos = pos + len + 1;
      end
      if (name_starts.size() != 0 && $urandom_range(2) == 0) begin
        tgt = ($urandom_range(9) == 0) ? $urandom_range(16383)
                                       : name_starts[$urandom_range(name_starts.size() - 1)];
        load_byte(pos, PTR_MASK | (tgt >> 8));
        load_byte(pos + 1, tgt & 8'hFF);
      end else begin
        load_byte(pos, 0);
      end
    end
    name_starts.push_back(base);
    if (name_starts.size() > 8) void'(name_starts.pop_front());
  endtask

  initial begin
    int addr, pick, base, start_mark;
    rst_n                = 1'b0;
    calm                 = 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.command        <= CMD_LOAD;
    in_ch.offset         <= '0;
    in_ch.data_byte      <= '0;
    in_ch.message_length <= '0;

    for (addr = 0; addr < MSG_BYTES; addr++) image[addr] = 8'($urandom_range(255));
    // Three plain labels, then a name made of a single empty label, then a broken one.
    image[0] = 8'h03;   image[4] = 8'h07;   image[12] = 8'h03;  image[16] = 8'h00;
    image[20] = 8'h00;  image[21] = 8'h00;
    image[24] = 8'h00;  image[25] = 8'h05;
    // A pointer to the first name, and a label followed by a pointer to that pointer.
    image[28] = 8'hC0;  image[29] = 8'h00;
    image[32] = 8'h02;  image[35] = 8'hC0;  image[36] = 8'h1C;
    // A pointer to itself runs into the hop limit.
    image[40] = 8'hC0;  image[41] = 8'h28;
    // Four labels looping back through a pointer fill up the event budget.
    image[44] = 8'h01;  image[46] = 8'h01;  image[48] = 8'h01;  image[50] = 8'h01;
    image[52] = 8'hC0;  image[53] = 8'h2C;
    // A pointer aimed at the highest target, far beyond the message.
    image[56] = 8'hFF;  image[57] = 8'hFF;
    // Length bytes above 0x3F that are still plain labels; the second runs past the end.
    image[60] = 8'h40;  image[125] = 8'h00;
    image[100] = 8'hBF;
    // A name that ends on the very last byte of the store.
    image[508] = 8'h02; image[511] = 8'h00;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // The low window and the last four bytes are written before any decode, and every
    // walk stays inside them, so no walk reads an unwritten entry.
    for (addr = 0; addr < WIN; addr++) load_byte(addr, image[addr]);
    for (addr = MSG_BYTES - 4; addr < MSG_BYTES; addr++) load_byte(addr, image[addr]);

    decode_name(0, MSG_BYTES);
    decode_name(20, MSG_BYTES);
    decode_name(24, MSG_BYTES);
    decode_name(28, MSG_BYTES);
    decode_name(32, MSG_BYTES);
    decode_name(40, MSG_BYTES);
    decode_name(44, MSG_BYTES);
    decode_name(56, MSG_BYTES);
    decode_name(60, MSG_BYTES);
    decode_name(100, WIN);
    decode_name(508, MSG_BYTES);
    decode_name(508, 511);
    decode_name(511, MSG_BYTES);
    decode_name(0, 0);
    decode_name(0, 1023);
    load_byte(511, 8'hFF);
    decode_name(508, MSG_BYTES);

    // Hold the sender back until the block has drained completely.
    wait_for_results();

    start_mark = items_sent;
    while (items_sent < start_mark + RANDOM_ITEMS) begin
      calm = (items_sent - start_mark >= 25) && (items_sent - start_mark < 70);
      pick = $urandom_range(99);
      base = $urandom_range(WIN - 16);
      if (pick < 75) begin
        write_name(base);
        if (pick >= 60) load_byte(base + $urandom_range(8), $urandom_range(255));
        decode_name(base, pick_length(base));
      end else if (pick < 90) begin
        decode_name($urandom_range(511), $urandom_range(WIN));
      end else begin
        repeat ($urandom_range(4, 1)) load_byte($urandom_range(511), $urandom_range(255));
      end
    end
    calm = 1'b0;

    wait_for_results();
    repeat (64) @(posedge clk);

    $display("Run covered %0d decodes and %0d byte loads.", decode_count, load_total);
    $display("Events seen: %0d labels, %0d pointers, %0d completions, %0d errors.",
             label_count, pointer_count, done_count, error_count);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
